/* design/bfca_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the best-fit coalescing allocator.
// No dependencies; the datapath, controller and top import this package.
package bfca_pkg;

   localparam int TABLE_ENTRIES = 64;
   localparam int IDX_W         = $clog2(TABLE_ENTRIES);
   localparam int CNT_W         = IDX_W + 1;
   localparam int GRAN_SHIFT    = 8;   // 256-byte granules

   typedef enum logic [1:0] {
      CMD_ALLOC = 2'd0,
      CMD_FREE  = 2'd1,
      CMD_PROBE = 2'd2,
      CMD_RSVD  = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_NOFIT   = 2'd1,
      ST_BADADDR = 2'd2,
      ST_ZERO    = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      CSR_POOL_BASE   = 2'd0,
      CSR_POOL_BYTES  = 2'd1,
      CSR_SPLIT_SLACK = 2'd2
   } csr_index_type;

   typedef enum logic [3:0] {
      S_INIT, S_IDLE, S_SCAN, S_DECIDE, S_WR_A, S_SH_RD, S_SH_WR, S_WR_B, S_DONE
   } state_type;

   typedef struct packed {
      logic [31:0] start;
      logic [31:0] granules;
      logic        in_use;
      logic [39:0] request;
   } entry_type;

   typedef struct packed {
      logic init;
      logic start;
      logic scan;
      logic decide;
      logic wr_a;
      logic sh_rd;
      logic sh_wr;
      logic wr_b;
      logic load_out;
   } ctl_cmd_type;

   typedef struct packed {
      logic             scan_done;
      logic             sh_zero;
      logic             sh_one;
      logic [CNT_W-1:0] live;
      logic [CNT_W-1:0] nfree;
   } dp_sts_type;

endpackage

/* design/bfca_if.sv */
`timescale 1ns / 1ps
// Valid/ready channel interfaces for request and response words.
// Depends on nothing; field widths follow the allocator's word layout.
interface bfca_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  cmd;
   logic [39:0] req_size;
   logic [47:0] free_address;
   modport source (output valid, cmd, req_size, free_address, input ready);
   modport sink   (input valid, cmd, req_size, free_address, output ready);
endinterface

interface bfca_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  status;
   logic [47:0] address;
   logic [39:0] granted_bytes;
   logic [39:0] used_bytes;
   logic [39:0] wasted_bytes;
   logic [39:0] free_bytes;
   logic [6:0]  free_chunks;
   modport source (output valid, status, address, granted_bytes, used_bytes,
                   wasted_bytes, free_bytes, free_chunks, input ready);
   modport sink   (input valid, status, address, granted_bytes, used_bytes,
                   wasted_bytes, free_bytes, free_chunks, output ready);
endinterface

/* design/bfca_ram.sv */
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module bfca_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end
endmodule

/* design/bfca_datapath.sv */
`timescale 1ns / 1ps
// Datapath: chunk table memory, scan and best-fit logic, totals, result register.
// Depends on bfca_pkg and bfca_ram; sequenced by bfca_ctrl.
module bfca_datapath (
   input  logic                 clock,
   input  logic                 reset,
   input  bfca_pkg::ctl_cmd_type ctl,
   output bfca_pkg::dp_sts_type  sts,
   input  logic                 csr_we,
   input  logic [1:0]           csr_index,
   input  logic [47:0]          csr_wdata,
   input  logic [1:0]           in_cmd,
   input  logic [39:0]          in_req_size,
   input  logic [47:0]          in_free_address,
   output logic [1:0]           out_status,
   output logic [47:0]          out_address,
   output logic [39:0]          out_granted_bytes,
   output logic [39:0]          out_used_bytes,
   output logic [39:0]          out_wasted_bytes,
   output logic [39:0]          out_free_bytes,
   output logic [6:0]           out_free_chunks
);
   import bfca_pkg::*;

   // configuration
   logic [47:0] pool_base_ff;
   logic [39:0] pool_bytes_ff, slack_ff;
   // control state
   logic [CNT_W-1:0] live_ff, live_in, nfree_ff, nfree_in, cur_ff, cur_in, sh_cnt_ff, sh_cnt_in;
   logic pend_ff, pend_in, found_ff, found_in, has_next_ff, has_next_in;
   logic has_a_ff, has_a_in, has_b_ff, has_b_in;
   // payload
   logic [1:0]  cmd_ff, cmd_in;
   logic [39:0] req_ff, req_in;
   logic [47:0] faddr_ff, faddr_in;
   logic [IDX_W-1:0] pend_idx_ff, pend_idx_in, sel_idx_ff, sel_idx_in;
   logic [IDX_W-1:0] a_idx_ff, a_idx_in, b_idx_ff, b_idx_in, sh_src_ff, sh_src_in;
   logic [1:0]  sh_d_ff, sh_d_in;
   logic        sh_up_ff, sh_up_in;
   entry_type   sel_ff, sel_in, last_ff, last_in, hprev_ff, hprev_in, nxt_ff, nxt_in;
   entry_type   a_ent_ff, a_ent_in, b_ent_ff, b_ent_in;
   logic [39:0] used_ff, used_in, wasted_ff, wasted_in, ftot_ff, ftot_in;
   logic [1:0]  res_status_ff, res_status_in;
   logic [47:0] res_addr_ff, res_addr_in;
   logic [39:0] res_granted_ff, res_granted_in;

   // memory ports
   logic             ram_we;
   logic [IDX_W-1:0] ram_waddr, ram_raddr, sh_dst;
   entry_type        ram_wdata, ram_rdata;

   // scan and decide terms
   logic [47:0] e_addr, sel_addr;
   logic        e_fit;
   logic [40:0] r_sum;
   logic [32:0] r_gran;
   logic [39:0] sel_bytes, granted;
   logic        split;
   logic [31:0] new_gran, merged_gran;
   logic        mn, mp;
   logic [1:0]  d_cnt;
   logic [IDX_W-1:0] t_idx;

   bfca_ram #(.WIDTH($bits(entry_type)), .DEPTH(TABLE_ENTRIES)) u_table (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   assign sh_dst    = sh_up_ff ? sh_src_ff - IDX_W'(sh_d_ff) : sh_src_ff + IDX_W'(1);
   assign ram_raddr = ctl.sh_rd ? sh_src_ff : cur_ff[IDX_W-1:0];

   always_comb begin
      ram_we    = 1'b0;
      ram_waddr = '0;
      ram_wdata = ram_rdata;
      if (ctl.init) begin
         ram_we    = 1'b1;
         ram_wdata = '{start: 32'd0, granules: pool_bytes_ff[39:8], in_use: 1'b0,
                       request: 40'd0};
      end else if (ctl.wr_a && has_a_ff) begin
         ram_we    = 1'b1;
         ram_waddr = a_idx_ff;
         ram_wdata = a_ent_ff;
      end else if (ctl.sh_wr) begin
         ram_we    = 1'b1;
         ram_waddr = sh_dst;
      end else if (ctl.wr_b && has_b_ff) begin
         ram_we    = 1'b1;
         ram_waddr = b_idx_ff;
         ram_wdata = b_ent_ff;
      end
   end

   assign e_addr    = pool_base_ff + {8'h00, ram_rdata.start, 8'h00};
   assign e_fit     = !ram_rdata.in_use && ({ram_rdata.granules, 8'h00} >= req_ff);
   assign sel_addr  = pool_base_ff + {8'h00, sel_ff.start, 8'h00};
   assign r_sum     = {1'b0, req_ff} + 41'd255;
   assign r_gran    = r_sum[40:8];
   assign sel_bytes = {sel_ff.granules, 8'h00};
   assign split     = (({2'b00, sel_bytes} > {r_gran, 9'h000}) ||
                       ((sel_bytes - req_ff) >= slack_ff))
                      && (live_ff < CNT_W'(TABLE_ENTRIES))
                      && ({1'b0, sel_ff.granules} > r_gran);
   assign new_gran  = split ? r_gran[31:0] : sel_ff.granules;
   assign granted   = {new_gran, 8'h00};
   assign mn        = has_next_ff && !nxt_ff.in_use;
   assign mp        = (sel_idx_ff != '0) && !hprev_ff.in_use;
   assign d_cnt     = {1'b0, mn} + {1'b0, mp};
   assign t_idx     = mp ? sel_idx_ff - IDX_W'(1) : sel_idx_ff;
   assign merged_gran = sel_ff.granules + (mn ? nxt_ff.granules : 32'd0);

   always_comb begin
      live_in = live_ff;       nfree_in = nfree_ff;     cur_in = cur_ff;
      sh_cnt_in = sh_cnt_ff;   pend_in = pend_ff;       found_in = found_ff;
      has_next_in = has_next_ff; has_a_in = has_a_ff;   has_b_in = has_b_ff;
      cmd_in = cmd_ff;         req_in = req_ff;         faddr_in = faddr_ff;
      pend_idx_in = pend_idx_ff; sel_idx_in = sel_idx_ff;
      a_idx_in = a_idx_ff;     b_idx_in = b_idx_ff;     sh_src_in = sh_src_ff;
      sh_d_in = sh_d_ff;       sh_up_in = sh_up_ff;
      sel_in = sel_ff;         last_in = last_ff;       hprev_in = hprev_ff;
      nxt_in = nxt_ff;         a_ent_in = a_ent_ff;     b_ent_in = b_ent_ff;
      used_in = used_ff;       wasted_in = wasted_ff;   ftot_in = ftot_ff;
      res_status_in = res_status_ff; res_addr_in = res_addr_ff;
      res_granted_in = res_granted_ff;

      if (ctl.init) begin
         live_in   = (pool_bytes_ff[39:8] != '0) ? CNT_W'(1) : '0;
         nfree_in  = live_in;
         used_in   = '0;
         wasted_in = '0;
         ftot_in   = {pool_bytes_ff[39:8], 8'h00};
      end

      if (ctl.start) begin
         cmd_in = in_cmd;  req_in = in_req_size;  faddr_in = in_free_address;
         cur_in = '0;  pend_in = 1'b0;  found_in = 1'b0;  has_next_in = 1'b0;
      end

      if (ctl.scan) begin
         // issue the next read while the previous word is evaluated
         pend_in = 1'b0;
         if (cur_ff < live_ff) begin
            pend_in     = 1'b1;
            pend_idx_in = cur_ff[IDX_W-1:0];
            cur_in      = cur_ff + CNT_W'(1);
         end
         if (pend_ff) begin
            last_in = ram_rdata;
            if (cmd_ff == CMD_FREE) begin
               if (!found_ff && ram_rdata.in_use && e_addr == faddr_ff) begin
                  found_in   = 1'b1;
                  sel_in     = ram_rdata;
                  sel_idx_in = pend_idx_ff;
                  hprev_in   = last_ff;
               end
               if (found_ff && pend_idx_ff == sel_idx_ff + IDX_W'(1)) begin
                  nxt_in      = ram_rdata;
                  has_next_in = 1'b1;
               end
            end else if (e_fit && (!found_ff || ram_rdata.granules < sel_ff.granules)) begin
               found_in   = 1'b1;
               sel_in     = ram_rdata;
               sel_idx_in = pend_idx_ff;
            end
         end
      end

      if (ctl.decide) begin
         has_a_in = 1'b0;  has_b_in = 1'b0;  sh_cnt_in = '0;
         res_status_in = ST_OK;  res_addr_in = '0;  res_granted_in = '0;
         unique case (cmd_ff)
            CMD_ALLOC, CMD_PROBE: begin
               if (req_ff == '0) begin
                  res_status_in = ST_ZERO;
               end else if (!found_ff) begin
                  res_status_in = ST_NOFIT;
               end else if (cmd_ff == CMD_ALLOC) begin
                  res_addr_in    = sel_addr;
                  res_granted_in = granted;
                  has_a_in  = 1'b1;
                  a_idx_in  = sel_idx_ff;
                  a_ent_in  = '{start: sel_ff.start, granules: new_gran, in_use: 1'b1,
                                request: req_ff};
                  has_b_in  = split;
                  b_idx_in  = sel_idx_ff + IDX_W'(1);
                  b_ent_in  = '{start: sel_ff.start + r_gran[31:0],
                                granules: sel_ff.granules - r_gran[31:0],
                                in_use: 1'b0, request: 40'd0};
                  sh_up_in  = 1'b0;
                  sh_d_in   = 2'd1;
                  sh_src_in = IDX_W'(live_ff - CNT_W'(1));
                  sh_cnt_in = split ? live_ff - CNT_W'(1) - CNT_W'(sel_idx_ff) : '0;
                  live_in   = live_ff + CNT_W'(split);
                  nfree_in  = split ? nfree_ff : nfree_ff - CNT_W'(1);
                  used_in   = used_ff + req_ff;
                  wasted_in = wasted_ff + granted - req_ff;
                  ftot_in   = ftot_ff - granted;
               end
            end
            CMD_FREE: begin
               if (!found_ff) begin
                  res_status_in = ST_BADADDR;
               end else begin
                  used_in   = used_ff - sel_ff.request;
                  wasted_in = wasted_ff - (sel_bytes - sel_ff.request);
                  ftot_in   = ftot_ff + sel_bytes;
                  has_a_in  = 1'b1;
                  a_idx_in  = t_idx;
                  a_ent_in  = mp ? '{start: hprev_ff.start,
                                     granules: hprev_ff.granules + merged_gran,
                                     in_use: 1'b0, request: 40'd0}
                                 : '{start: sel_ff.start, granules: merged_gran,
                                     in_use: 1'b0, request: 40'd0};
                  // close the gap left by merged neighbors
                  sh_up_in  = 1'b1;
                  sh_d_in   = d_cnt;
                  sh_src_in = t_idx + IDX_W'(1) + IDX_W'(d_cnt);
                  sh_cnt_in = (d_cnt != 2'd0)
                              ? live_ff - CNT_W'(1) - CNT_W'(d_cnt) - CNT_W'(t_idx) : '0;
                  live_in   = live_ff - CNT_W'(d_cnt);
                  nfree_in  = nfree_ff + CNT_W'(1) - CNT_W'(d_cnt);
               end
            end
            default: begin
            end
         endcase
      end

      if (ctl.sh_wr) begin
         sh_src_in = sh_up_ff ? sh_src_ff + IDX_W'(1) : sh_src_ff - IDX_W'(1);
         sh_cnt_in = sh_cnt_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pool_base_ff  <= '0;
         pool_bytes_ff <= 40'd1073741824;
         slack_ff      <= 40'd134217728;
         live_ff  <= '0;  nfree_ff <= '0;  cur_ff <= '0;  sh_cnt_ff <= '0;
         pend_ff  <= 1'b0;  found_ff <= 1'b0;  has_next_ff <= 1'b0;
         has_a_ff <= 1'b0;  has_b_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               CSR_POOL_BASE:   pool_base_ff  <= csr_wdata;
               CSR_POOL_BYTES:  pool_bytes_ff <= csr_wdata[39:0];
               CSR_SPLIT_SLACK: slack_ff      <= csr_wdata[39:0];
               default: begin
               end
            endcase
         end
         live_ff  <= live_in;  nfree_ff <= nfree_in;  cur_ff <= cur_in;
         sh_cnt_ff <= sh_cnt_in;  pend_ff <= pend_in;  found_ff <= found_in;
         has_next_ff <= has_next_in;  has_a_ff <= has_a_in;  has_b_ff <= has_b_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff <= cmd_in;  req_ff <= req_in;  faddr_ff <= faddr_in;
      pend_idx_ff <= pend_idx_in;  sel_idx_ff <= sel_idx_in;
      a_idx_ff <= a_idx_in;  b_idx_ff <= b_idx_in;  sh_src_ff <= sh_src_in;
      sh_d_ff <= sh_d_in;  sh_up_ff <= sh_up_in;
      sel_ff <= sel_in;  last_ff <= last_in;  hprev_ff <= hprev_in;  nxt_ff <= nxt_in;
      a_ent_ff <= a_ent_in;  b_ent_ff <= b_ent_in;
      used_ff <= used_in;  wasted_ff <= wasted_in;  ftot_ff <= ftot_in;
      res_status_ff <= res_status_in;  res_addr_ff <= res_addr_in;
      res_granted_ff <= res_granted_in;
      if (ctl.load_out) begin
         out_status        <= res_status_ff;
         out_address       <= res_addr_ff;
         out_granted_bytes <= res_granted_ff;
         out_used_bytes    <= used_ff;
         out_wasted_bytes  <= wasted_ff;
         out_free_bytes    <= ftot_ff;
         out_free_chunks   <= nfree_ff;
      end
   end

   assign sts.scan_done = (cur_ff >= live_ff) && !pend_ff;
   assign sts.sh_zero   = (sh_cnt_ff == '0);
   assign sts.sh_one    = (sh_cnt_ff == CNT_W'(1));
   assign sts.live      = live_ff;
   assign sts.nfree     = nfree_ff;
endmodule

/* design/bfca_ctrl.sv */
`timescale 1ns / 1ps
// Controller: sequences scan, decide, table writes and shifts; owns handshakes.
// Depends on bfca_pkg.
module bfca_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  pool_write,
   input  logic                  req_valid,
   output logic                  req_ready,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  bfca_pkg::dp_sts_type  sts,
   output bfca_pkg::ctl_cmd_type ctl
);
   import bfca_pkg::*;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      ctl       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         S_INIT: begin
            ctl.init = 1'b1;
            state_in = S_IDLE;
         end
         S_IDLE: begin
            req_ready = !pool_write;
            if (pool_write) begin
               state_in = S_INIT;
            end else if (req_valid) begin
               ctl.start = 1'b1;
               state_in  = S_SCAN;
            end
         end
         S_SCAN: begin
            ctl.scan = 1'b1;
            if (sts.scan_done) begin
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            ctl.decide = 1'b1;
            state_in   = S_WR_A;
         end
         S_WR_A: begin
            ctl.wr_a = 1'b1;
            state_in = sts.sh_zero ? S_WR_B : S_SH_RD;
         end
         S_SH_RD: begin
            ctl.sh_rd = 1'b1;
            state_in  = S_SH_WR;
         end
         S_SH_WR: begin
            ctl.sh_wr = 1'b1;
            state_in  = sts.sh_one ? S_WR_B : S_SH_RD;
         end
         S_WR_B: begin
            ctl.wr_b = 1'b1;
            state_in = S_DONE;
         end
         S_DONE: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               ctl.load_out = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_INIT;
      endcase
      rsp_valid_in = ctl.load_out ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);
   end

   assign rsp_valid = rsp_valid_ff;
endmodule

/* design/best_fit_coalescing_allocator.sv */
`timescale 1ns / 1ps
// Best-fit coalescing allocator over a pool of 256-byte granules.
// Depends on bfca_pkg, bfca_if, bfca_ram, bfca_datapath and bfca_ctrl.
//
// Usage: write pool_base, pool_bytes and split_slack_bytes through the csr_
// port while the block is idle; a pool_bytes write rebuilds the chunk table
// in the S_INIT state, and the request side is not ready in the write cycle
// or during the rebuild. Requests arrive as words on req_chan (allocate, free,
// probe); each gives exactly one word on rsp_chan with status, address, granted
// bytes and the usage totals.
// Sequence: after a request is accepted, the block scans every table entry in
// use (the scan reads one entry a cycle from the table memory's read port),
// decides, writes the chosen entry, moves entries with a read and a write each
// when a split inserts or a merge removes an entry, writes the split tail and
// loads the result. One request is worked on at a time; the next is accepted
// once the controller is back in its idle state after the result is loaded.
// Reset: synchronous, active high; control and configuration registers take
// their reset values and the S_INIT state entered on reset writes the single free chunk covering the pool.
// Stall: a finished word sits in the output register until rsp_chan.ready; a
// new request is accepted meanwhile, and its result waits for that register.
module best_fit_coalescing_allocator (
   input  logic       clock,
   input  logic       reset,
   bfca_req_if.sink   req_chan,
   bfca_rsp_if.source rsp_chan,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [47:0] csr_wdata
);
   import bfca_pkg::*;

   ctl_cmd_type ctl;
   dp_sts_type  sts;
   logic        pool_write;

   assign pool_write = csr_we && (csr_index == CSR_POOL_BYTES);

   bfca_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .pool_write (pool_write),
      .req_valid  (req_chan.valid),
      .req_ready  (req_chan.ready),
      .rsp_valid  (rsp_chan.valid),
      .rsp_ready  (rsp_chan.ready),
      .sts        (sts),
      .ctl        (ctl)
   );

   bfca_datapath u_dp (
      .clock             (clock),
      .reset             (reset),
      .ctl               (ctl),
      .sts               (sts),
      .csr_we            (csr_we),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .in_cmd            (req_chan.cmd),
      .in_req_size       (req_chan.req_size),
      .in_free_address   (req_chan.free_address),
      .out_status        (rsp_chan.status),
      .out_address       (rsp_chan.address),
      .out_granted_bytes (rsp_chan.granted_bytes),
      .out_used_bytes    (rsp_chan.used_bytes),
      .out_wasted_bytes  (rsp_chan.wasted_bytes),
      .out_free_bytes    (rsp_chan.free_bytes),
      .out_free_chunks   (rsp_chan.free_chunks)
   );

   a_live_bound: assert property (@(posedge clock) disable iff (reset)
      sts.live <= CNT_W'(TABLE_ENTRIES))
      else $error("chunk count beyond table size");

   a_free_le_live: assert property (@(posedge clock) disable iff (reset)
      sts.nfree <= sts.live)
      else $error("free chunk count exceeds live chunks");

   a_rsp_from_load: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_chan.valid) |-> $past(ctl.load_out))
      else $error("response word appeared without a load");

   a_accept_scans: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready) |=> ctl.scan)
      else $error("accepted request did not start a scan");
endmodule

/* tb/alloc_checker.sv */
`timescale 1ns / 1ps
// Response checker for the best-fit coalescing allocator: tracks the chunk
// table and usage totals from accepted words and register writes.
// Depends on bfca_pkg and the bfca_req_if / bfca_rsp_if channel interfaces.
module alloc_checker (
   input  logic        clock,
   input  logic        reset,
   bfca_req_if         req_chan,
   bfca_rsp_if         rsp_chan,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [47:0] csr_wdata,
   output int          fail_count,
   output int          pending,
   output int          n_checked,
   output int          n_granted,
   output int          n_freed
);
   import bfca_pkg::*;

   typedef struct packed {
      logic [1:0]  status;
      logic [47:0] address;
      logic [39:0] granted;
      logic [39:0] used;
      logic [39:0] wasted;
      logic [39:0] free_b;
      logic [6:0]  nfree;
   } outcome_type;

   logic [31:0] e_start [TABLE_ENTRIES];
   logic [31:0] e_gran  [TABLE_ENTRIES];
   bit          e_use   [TABLE_ENTRIES];
   logic [39:0] e_req   [TABLE_ENTRIES];
   int          live;
   logic [47:0] base_r;
   logic [39:0] pool_r;
   logic [39:0] slack_r;
   logic [39:0] used_t;
   logic [39:0] wasted_t;
   logic [39:0] free_t;
   outcome_type expected_q [$];

   initial begin
      fail_count = 0;
      pending    = 0;
      n_checked  = 0;
      n_granted  = 0;
      n_freed    = 0;
   end

   function automatic void clear_slot(int k);
      e_start[k] = '0;
      e_gran[k]  = '0;
      e_use[k]   = 1'b0;
      e_req[k]   = '0;
   endfunction

   function automatic void copy_slot(int dst, int src);
      e_start[dst] = e_start[src];
      e_gran[dst]  = e_gran[src];
      e_use[dst]   = e_use[src];
      e_req[dst]   = e_req[src];
   endfunction

   function automatic void drop_slot(int k);
      for (int j = k; j + 1 < live; j++)
         copy_slot(j, j + 1);
      live--;
      clear_slot(live);
   endfunction

   function automatic void rebuild_table();
      logic [63:0] g;
      g = {24'b0, pool_r} >> GRAN_SHIFT;
      if (g > 64'hFFFF_FFFF)
         g = 64'hFFFF_FFFF;
      for (int k = 0; k < TABLE_ENTRIES; k++)
         clear_slot(k);
      live = 0;
      if (g != 0) begin
         e_gran[0] = g[31:0];
         live = 1;
      end
      used_t   = '0;
      wasted_t = '0;
      free_t   = 40'(g << GRAN_SHIFT);
   endfunction

   function automatic logic [47:0] chunk_addr(int k);
      return 48'({16'b0, base_r} + ({32'b0, e_start[k]} << GRAN_SHIFT));
   endfunction

   function automatic outcome_type predict_outcome(logic [1:0] c, logic [39:0] sz,
                                                   logic [47:0] fa);
      outcome_type o;
      int          best;
      int          hit;
      logic [63:0] nb;
      logic [63:0] rg;
      o = '0;
      o.status = ST_OK;
      if (c == CMD_ALLOC || c == CMD_PROBE) begin
         if (sz == 0) begin
            o.status = ST_ZERO;
         end else begin
            best = -1;
            for (int k = 0; k < live; k++) begin
               nb = {32'b0, e_gran[k]} << GRAN_SHIFT;
               if (!e_use[k] && nb >= {24'b0, sz})
                  if (best < 0 || e_gran[k] < e_gran[best])
                     best = k;
            end
            if (best < 0) begin
               o.status = ST_NOFIT;
            end else if (c == CMD_ALLOC) begin
               rg = ({24'b0, sz} + 64'd255) >> GRAN_SHIFT;
               nb = {32'b0, e_gran[best]} << GRAN_SHIFT;
               e_use[best] = 1'b1;
               e_req[best] = sz;
               // split the tail if oversized or leftover >= slack, given a free slot
               if ((nb > ((2 * rg) << GRAN_SHIFT) || nb - {24'b0, sz} >= {24'b0, slack_r})
                   && live < TABLE_ENTRIES && {32'b0, e_gran[best]} > rg) begin
                  for (int k = live; k > best + 1; k--)
                     copy_slot(k, k - 1);
                  e_start[best + 1] = e_start[best] + rg[31:0];
                  e_gran[best + 1]  = e_gran[best] - rg[31:0];
                  e_use[best + 1]   = 1'b0;
                  e_req[best + 1]   = '0;
                  e_gran[best]      = rg[31:0];
                  live++;
               end
               o.granted = 40'({32'b0, e_gran[best]} << GRAN_SHIFT);
               o.address = chunk_addr(best);
               used_t   = used_t + sz;
               wasted_t = wasted_t + o.granted - sz;
               free_t   = free_t - o.granted;
            end
         end
      end else if (c == CMD_FREE) begin
         hit = -1;
         for (int k = 0; k < live; k++)
            if (hit < 0 && e_use[k] && chunk_addr(k) == fa)
               hit = k;
         if (hit < 0) begin
            o.status = ST_BADADDR;
         end else begin
            nb = {32'b0, e_gran[hit]} << GRAN_SHIFT;
            used_t   = used_t - e_req[hit];
            wasted_t = wasted_t - (40'(nb) - e_req[hit]);
            free_t   = free_t + 40'(nb);
            e_use[hit] = 1'b0;
            e_req[hit] = '0;
            if (hit + 1 < live && !e_use[hit + 1]) begin
               e_gran[hit] = e_gran[hit] + e_gran[hit + 1];
               drop_slot(hit + 1);
            end
            if (hit > 0 && !e_use[hit - 1]) begin
               e_gran[hit - 1] = e_gran[hit - 1] + e_gran[hit];
               drop_slot(hit);
            end
         end
      end
      o.used   = used_t;
      o.wasted = wasted_t;
      o.free_b = free_t;
      for (int k = 0; k < live; k++)
         if (!e_use[k])
            o.nfree = o.nfree + 7'd1;
      return o;
   endfunction

   always @(posedge clock) begin
      outcome_type exp_w;
      outcome_type got_w;
      if (reset) begin
         base_r  = '0;
         pool_r  = 40'd1073741824;
         slack_r = 40'd134217728;
         rebuild_table();
         expected_q.delete();
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            got_w = {rsp_chan.status, rsp_chan.address, rsp_chan.granted_bytes,
                     rsp_chan.used_bytes, rsp_chan.wasted_bytes, rsp_chan.free_bytes,
                     rsp_chan.free_chunks};
            n_checked++;
            if (expected_q.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("unexpected response word: %h", got_w);
            end else begin
               exp_w = expected_q.pop_front();
               if (exp_w.status !== got_w.status || exp_w.address !== got_w.address ||
                   exp_w.granted !== got_w.granted || exp_w.used !== got_w.used ||
                   exp_w.wasted !== got_w.wasted || exp_w.free_b !== got_w.free_b ||
                   exp_w.nfree !== got_w.nfree) begin
                  fail_count++;
                  if (fail_count <= 10) begin
                     $display("exp: st %0d addr %h grant %h used %h waste %h free %h n %0d",
                              exp_w.status, exp_w.address, exp_w.granted, exp_w.used,
                              exp_w.wasted, exp_w.free_b, exp_w.nfree);
                     $display("got: st %0d addr %h grant %h used %h waste %h free %h n %0d",
                              got_w.status, got_w.address, got_w.granted, got_w.used,
                              got_w.wasted, got_w.free_b, got_w.nfree);
                  end
               end
            end
         end
         if (csr_we) begin
            case (csr_index)
               CSR_POOL_BASE:   base_r = csr_wdata;
               CSR_POOL_BYTES: begin
                  pool_r = csr_wdata[39:0];
                  rebuild_table();
               end
               CSR_SPLIT_SLACK: slack_r = csr_wdata[39:0];
               default: ;
            endcase
         end
         if (req_chan.valid && req_chan.ready) begin
            exp_w = predict_outcome(req_chan.cmd, req_chan.req_size, req_chan.free_address);
            if (req_chan.cmd == CMD_ALLOC && exp_w.status == ST_OK)
               n_granted++;
            if (req_chan.cmd == CMD_FREE && exp_w.status == ST_OK)
               n_freed++;
            expected_q.push_back(exp_w);
         end
      end
      pending = expected_q.size();
   end

endmodule

/* tb/tb.sv */
`timescale 1ns / 1ps
// Top of the allocator testbench: clock, reset, request and register stimulus,
// response-side stalls and the verdict. Depends on bfca_pkg, bfca_if,
// alloc_checker and the best_fit_coalescing_allocator design.
module tb;
   import bfca_pkg::*;

   localparam int IDLE_LIMIT = 4000;

   logic        clock;
   logic        reset;
   logic        csr_we;
   logic [1:0]  csr_index;
   logic [47:0] csr_wdata;
   int          fail_count;
   int          pending;
   int          n_checked;
   int          n_granted;
   int          n_freed;
   int          idle_cycles;
   bit          send_burst;
   bit          recv_burst;
   bit          hold_long;
   logic [47:0] base_now;
   logic [47:0] held_offsets [$];

   bfca_req_if req_chan ();
   bfca_rsp_if rsp_chan ();

   best_fit_coalescing_allocator i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   alloc_checker i_alloc_check (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .rsp_chan   (rsp_chan),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .fail_count (fail_count),
      .pending    (pending),
      .n_checked  (n_checked),
      .n_granted  (n_granted),
      .n_freed    (n_freed)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("timeout: no word moved for %0d cycles", IDLE_LIMIT);
         $display("tb NOT OK");
         $finish;
      end
   end

   // response side: random stalls, one long hold-off on request
   initial begin
      int n;
      rsp_chan.ready = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_long) begin
            rsp_chan.ready <= 1'b0;
            repeat (600) @(posedge clock);
            hold_long = 1'b0;
         end
         n = recv_burst ? 0 : $urandom_range(0, 14);
         if (n > 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (n) @(posedge clock);
         end
         rsp_chan.ready <= 1'b1;
         @(posedge clock);
         while (!rsp_chan.valid) @(posedge clock);
         if (rsp_chan.status == ST_OK && rsp_chan.granted_bytes != 0)
            held_offsets.push_back(rsp_chan.address - base_now);
      end
   end

   task automatic send_word(cmd_type c, logic [39:0] sz, logic [47:0] fa);
      int gap;
      gap = send_burst ? 0 : $urandom_range(0, 14);
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.cmd          <= c;
      req_chan.req_size     <= sz;
      req_chan.free_address <= fa;
      req_chan.valid        <= 1'b1;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
   endtask

   // hold off until every response is back and the block has gone quiet
   task automatic drain();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (220) @(posedge clock);
   endtask

   task automatic write_reg(csr_index_type idx, logic [47:0] d);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= d;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
      if (idx == CSR_POOL_BASE)
         base_now = d;
      if (idx == CSR_POOL_BYTES)
         held_offsets.delete();
   endtask

   function automatic logic [39:0] pick_size(int span);
      int k;
      k = $urandom_range(0, 9);
      if (k < 6)
         return 40'($urandom_range(1, span)) * 40'd256 - 40'($urandom_range(0, 255));
      else if (k < 9)
         return 40'($urandom_range(1, span)) * 40'd256;
      return 40'({$urandom, $urandom});
   endfunction

   task automatic free_held();
      int j;
      logic [47:0] off;
      j = $urandom_range(0, held_offsets.size() - 1);
      off = held_offsets[j];
      // keep the entry now and then, so a double free follows later
      if ($urandom_range(0, 9) != 0)
         held_offsets.delete(j);
      send_word(CMD_FREE, 40'({$urandom, $urandom}), base_now + off);
   endtask

   task automatic random_traffic(int n, int span);
      int r;
      for (int i = 0; i < n; i++) begin
         if (i % 40 == 0) begin
            send_burst = ($urandom_range(0, 4) == 0);
            recv_burst = ($urandom_range(0, 4) == 0);
         end
         r = $urandom_range(0, 99);
         if (r < 48)
            send_word(CMD_ALLOC, pick_size(span), 48'({$urandom, $urandom}));
         else if (r < 80 && held_offsets.size() > 0)
            free_held();
         else if (r < 88)
            send_word(CMD_PROBE, pick_size(span), 48'({$urandom, $urandom}));
         else if (r < 93)
            send_word(CMD_FREE, 40'({$urandom, $urandom}),
                      ($urandom_range(0, 1) != 0) ? 48'({$urandom, $urandom})
                         : base_now + 48'($urandom_range(0, 4 * span)) * 48'd256);
         else if (r < 96)
            send_word(($urandom_range(0, 1) != 0) ? CMD_ALLOC : CMD_PROBE, '0,
                      48'({$urandom, $urandom}));
         else if (r < 98)
            send_word(CMD_RSVD, 40'({$urandom, $urandom}), 48'({$urandom, $urandom}));
         else
            send_word(CMD_ALLOC, 40'({$urandom, $urandom}), '0);
      end
      send_burst = 1'b0;
      recv_burst = 1'b0;
   endtask

   initial begin
      reset = 1'b1;
      req_chan.valid        = 1'b0;
      req_chan.cmd          = CMD_ALLOC;
      req_chan.req_size     = '0;
      req_chan.free_address = '0;
      csr_we     = 1'b0;
      csr_index  = CSR_POOL_BASE;
      csr_wdata  = '0;
      send_burst = 1'b0;
      recv_burst = 1'b0;
      hold_long  = 1'b0;
      base_now   = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);

      // directed: power-on pool and slack
      send_word(CMD_ALLOC, '0, '0);
      send_word(CMD_PROBE, '0, '0);
      send_word(CMD_PROBE, 40'd1, '0);
      send_word(CMD_PROBE, '1, '0);
      send_word(CMD_ALLOC, '1, '0);
      send_word(CMD_ALLOC, 40'd1, '0);
      send_word(CMD_ALLOC, 40'd300, '0);
      send_word(CMD_ALLOC, 40'd134217728, '0);
      send_word(CMD_ALLOC, 40'd512, '0);
      send_word(CMD_FREE, '0, 48'h123);
      send_word(CMD_FREE, '1, '1);
      send_word(CMD_FREE, '0, '0);
      send_word(CMD_FREE, '0, '0);
      send_word(CMD_FREE, '0, 48'd256);
      send_word(CMD_RSVD, '1, '1);
      send_word(CMD_RSVD, '0, '0);
      drain();
      while (held_offsets.size() > 0)
         free_held();
      drain();

      // wrapped base, zero slack splits loose fits, small pool fills the table
      write_reg(CSR_POOL_BASE, '1);
      write_reg(CSR_SPLIT_SLACK, '0);
      write_reg(CSR_POOL_BYTES, 48'd200 * 48'd256 + 48'd77);
      random_traffic(90, 6);
      // fill the output register and stall the request side
      drain();
      hold_long = 1'b1;
      send_burst = 1'b1;
      for (int i = 0; i < 8; i++)
         send_word(CMD_ALLOC, pick_size(4), '0);
      send_burst = 1'b0;
      random_traffic(90, 6);
      drain();

      // move live chunks, then free through the new base
      write_reg(CSR_POOL_BASE, 48'h0000_1234_5600);
      random_traffic(60, 6);
      drain();

      // split only on oversize chunks
      write_reg(CSR_SPLIT_SLACK, 48'hFF_FFFF_FFFF);
      write_reg(CSR_POOL_BYTES, 48'd300 * 48'd256);
      random_traffic(140, 20);
      drain();

      // empty pools
      write_reg(CSR_POOL_BYTES, '0);
      send_word(CMD_ALLOC, 40'd1, '0);
      send_word(CMD_PROBE, 40'd1, '0);
      send_word(CMD_FREE, '0, base_now);
      drain();
      write_reg(CSR_POOL_BYTES, 48'd255);
      send_word(CMD_ALLOC, 40'd1, '0);
      send_word(CMD_PROBE, 40'd255, '0);
      drain();

      // largest pool, capped at the granule limit
      write_reg(CSR_POOL_BASE, 48'hFFFF_0000_0000);
      write_reg(CSR_SPLIT_SLACK, 48'd1 << 30);
      write_reg(CSR_POOL_BYTES, 48'hFF_FFFF_FFFF);
      send_word(CMD_PROBE, 40'hFF_FFFF_FF00, '0);
      send_word(CMD_ALLOC, 40'hFF_FFFF_FF00, '0);
      send_word(CMD_ALLOC, 40'd1, '0);
      send_word(CMD_FREE, '0, base_now);
      random_traffic(120, 1 << 26);
      drain();

      // moderate pool, base back to zero
      write_reg(CSR_POOL_BASE, '0);
      write_reg(CSR_SPLIT_SLACK, 48'd2048);
      write_reg(CSR_POOL_BYTES, 48'd120 * 48'd256);
      random_traffic(80, 10);
      drain();

      repeat (250) @(posedge clock);
      $display("checked %0d responses: %0d grants, %0d frees, across pool, base and slack",
               n_checked, n_granted, n_freed);
      $display("settings including empty, wrapped and capped pools");
      if (fail_count == 0 && pending == 0)
         $display("tb OK");
      else
         $display("tb NOT OK");
      $finish;
   end

endmodule
